@@ rtl/core/kmh_pkg.sv @@
// Shared types and constants for the k-means hub selection block.
`timescale 1ns / 1ps
`default_nettype none
package kmh_pkg;

  localparam int COORD_W  = 16;
  localparam int ID_W     = 16;
  localparam int PICK_W   = 6;
  localparam int NC_W     = 5;
  localparam int MI_W     = 10;
  localparam int CFG_W    = 10;
  localparam int OUT_CL_W = 4;

  typedef enum logic [1:0] {
    CMD_CLEAR = 2'd0,
    CMD_LOAD  = 2'd1,
    CMD_PICK  = 2'd2,
    CMD_RUN   = 2'd3
  } cmd_t;

  localparam logic REG_NUM_CLUSTERS = 1'b0;
  localparam logic REG_MAX_ITER     = 1'b1;

  localparam logic [NC_W-1:0] NC_RESET = 5'd10;
  localparam logic [MI_W-1:0] MI_RESET = 10'd100;

  typedef enum logic [4:0] {
    S_IDLE,
    S_PICK,
    S_LBL_INIT,
    S_IT_CHECK,
    S_AS_RD,
    S_AS_MUL,
    S_AS_CMP,
    S_AS_WR,
    S_SUM_RD,
    S_SUM_ACC,
    S_UPD_C,
    S_WAIT_X,
    S_WAIT_Y,
    S_UPD_NEXT,
    S_HUB_C,
    S_HUB_RD,
    S_HUB_MUL,
    S_HUB_CMP,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic sel_pick;
    logic pick_lat;
    logic ld_wr;
    logic clr;
    logic pick_wr;
    logic run_start;
    logic lbl_init;
    logic i_clr;
    logic i_inc;
    logic c_clr;
    logic c_inc;
    logic mul;
    logic cmp_as;
    logic lbl_wr;
    logic chg_clr;
    logic sum_clr;
    logic sum_acc;
    logic div_x_start;
    logic div_y_start;
    logic cen_x_wr;
    logic cen_y_wr;
    logic it_inc;
    logic hub_clr;
    logic hub_cmp;
    logic emit;
  } ctl_t;

  typedef struct packed {
    logic i_end;
    logic c_last;
    logic it_end;
    logic changed;
    logic cnt_zero;
    logic div_done;
  } sts_t;

endpackage
`default_nettype wire

@@ rtl/core/kmh_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module kmh_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire                                 clk,
  input  wire                                 we,
  input  wire [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire [WIDTH-1:0]                     wdata,
  input  wire [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                    rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

@@ rtl/core/kmh_div.sv @@
// Radix-2 restoring divider, signed dividend truncated toward zero.
`timescale 1ns / 1ps
`default_nettype none
module kmh_div
  import kmh_pkg::*;
#(
  parameter int SUM_W = 23,
  parameter int CNT_W = 7
) (
  input  wire                       clk,
  input  wire                       rst,
  input  wire                       start,
  input  wire signed [SUM_W-1:0]    dividend,
  input  wire [CNT_W-1:0]           divisor,
  output logic                      done,
  output logic signed [COORD_W-1:0] quotient
);

  localparam int RW  = CNT_W + 1;
  localparam int CTW = $clog2(SUM_W);

  logic [RW-1:0]    rem;
  logic [SUM_W-1:0] quo;
  logic [CNT_W-1:0] dvs;
  logic             neg;
  logic             run;
  logic [CTW-1:0]   cnt;
  logic [RW-1:0]    trial;
  logic             ge;
  logic [SUM_W-1:0] mag;

  assign mag   = dividend[SUM_W-1] ? SUM_W'(-dividend) : SUM_W'(dividend);
  assign trial = {rem[RW-2:0], quo[SUM_W-1]};
  assign ge    = trial >= {1'b0, dvs};
  assign quotient = neg ? -$signed(quo[COORD_W-1:0]) : $signed(quo[COORD_W-1:0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rem <= '0;
        quo <= mag;
        dvs <= divisor;
        neg <= dividend[SUM_W-1];
        cnt <= '0;
        run <= 1'b1;
      end else if (run) begin
        rem <= ge ? trial - {1'b0, dvs} : trial;
        quo <= {quo[SUM_W-2:0], ge};
        cnt <= cnt + 1'b1;
        if (cnt == CTW'(SUM_W - 1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/kmh_ctrl.sv @@
// Sequencer for clear, load, pick, Lloyd rounds and hub reporting.
`timescale 1ns / 1ps
`default_nettype none
module kmh_ctrl
  import kmh_pkg::*;
(
  input  wire             clk,
  input  wire             rst,
  input  wire             start,
  input  wire [1:0]       cmd,
  input  sts_t            sts,
  output logic            busy,
  output ctl_t            ctl
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != S_IDLE);

  always_comb begin
    state_next = state;
    ctl = '0;
    unique case (state)
      S_IDLE: begin
        ctl.sel_pick = 1'b1;
        if (start) begin
          unique case (cmd_t'(cmd))
            CMD_CLEAR: ctl.clr = 1'b1;
            CMD_LOAD:  ctl.ld_wr = 1'b1;
            CMD_PICK: begin
              ctl.pick_lat = 1'b1;
              state_next = S_PICK;
            end
            CMD_RUN: begin
              ctl.run_start = 1'b1;
              ctl.i_clr = 1'b1;
              state_next = S_LBL_INIT;
            end
            default: ;
          endcase
        end
      end
      S_PICK: begin
        ctl.pick_wr = 1'b1;
        state_next = S_IDLE;
      end
      S_LBL_INIT: begin
        if (sts.i_end) begin
          state_next = S_IT_CHECK;
        end else begin
          ctl.lbl_init = 1'b1;
          ctl.i_inc = 1'b1;
        end
      end
      S_IT_CHECK: begin
        if (sts.it_end) begin
          ctl.c_clr = 1'b1;
          state_next = S_HUB_C;
        end else begin
          ctl.chg_clr = 1'b1;
          ctl.i_clr = 1'b1;
          state_next = S_AS_RD;
        end
      end
      S_AS_RD: begin
        ctl.c_clr = 1'b1;
        if (sts.i_end) begin
          if (sts.changed) begin
            ctl.i_clr = 1'b1;
            ctl.sum_clr = 1'b1;
            state_next = S_SUM_RD;
          end else begin
            state_next = S_HUB_C;
          end
        end else begin
          state_next = S_AS_MUL;
        end
      end
      S_AS_MUL: begin
        ctl.mul = 1'b1;
        state_next = S_AS_CMP;
      end
      S_AS_CMP: begin
        ctl.cmp_as = 1'b1;
        if (sts.c_last) begin
          state_next = S_AS_WR;
        end else begin
          ctl.c_inc = 1'b1;
          state_next = S_AS_MUL;
        end
      end
      S_AS_WR: begin
        ctl.lbl_wr = 1'b1;
        ctl.i_inc = 1'b1;
        state_next = S_AS_RD;
      end
      S_SUM_RD: begin
        if (sts.i_end) begin
          ctl.c_clr = 1'b1;
          state_next = S_UPD_C;
        end else begin
          state_next = S_SUM_ACC;
        end
      end
      S_SUM_ACC: begin
        ctl.sum_acc = 1'b1;
        ctl.i_inc = 1'b1;
        state_next = S_SUM_RD;
      end
      S_UPD_C: begin
        if (sts.cnt_zero) begin
          state_next = S_UPD_NEXT;
        end else begin
          ctl.div_x_start = 1'b1;
          state_next = S_WAIT_X;
        end
      end
      S_WAIT_X: begin
        if (sts.div_done) begin
          ctl.cen_x_wr = 1'b1;
          ctl.div_y_start = 1'b1;
          state_next = S_WAIT_Y;
        end
      end
      S_WAIT_Y: begin
        if (sts.div_done) begin
          ctl.cen_y_wr = 1'b1;
          state_next = S_UPD_NEXT;
        end
      end
      S_UPD_NEXT: begin
        if (sts.c_last) begin
          ctl.it_inc = 1'b1;
          state_next = S_IT_CHECK;
        end else begin
          ctl.c_inc = 1'b1;
          state_next = S_UPD_C;
        end
      end
      S_HUB_C: begin
        ctl.hub_clr = 1'b1;
        ctl.i_clr = 1'b1;
        state_next = S_HUB_RD;
      end
      S_HUB_RD: begin
        state_next = sts.i_end ? S_EMIT : S_HUB_MUL;
      end
      S_HUB_MUL: begin
        ctl.mul = 1'b1;
        state_next = S_HUB_CMP;
      end
      S_HUB_CMP: begin
        ctl.hub_cmp = 1'b1;
        ctl.i_inc = 1'b1;
        state_next = S_HUB_RD;
      end
      S_EMIT: begin
        ctl.emit = 1'b1;
        if (sts.c_last) begin
          state_next = S_IDLE;
        end else begin
          ctl.c_inc = 1'b1;
          state_next = S_HUB_C;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

@@ rtl/core/kmh_dp.sv @@
// Datapath: node store, labels, centroids, sums, distance and hub search.
`timescale 1ns / 1ps
`default_nettype none
module kmh_dp
  import kmh_pkg::*;
#(
  parameter int MAX_NODES    = 64,
  parameter int MAX_CLUSTERS = 16
) (
  input  wire                       clk,
  input  wire                       rst,
  input  ctl_t                      ctl,
  output sts_t                      sts,
  input  wire                       cfg_we,
  input  wire                       cfg_index,
  input  wire [CFG_W-1:0]           cfg_data,
  input  wire [ID_W-1:0]            node_id,
  input  wire signed [COORD_W-1:0]  x_coord,
  input  wire signed [COORD_W-1:0]  y_coord,
  input  wire [PICK_W-1:0]          pick_index,
  output logic                      done,
  output logic [OUT_CL_W-1:0]       cluster,
  output logic [ID_W-1:0]           hub_id,
  output logic                      hub_found,
  output logic                      last
);

  localparam int AW    = MAX_NODES > 1 ? $clog2(MAX_NODES) : 1;
  localparam int CNTW  = $clog2(MAX_NODES + 1);
  localparam int CW    = MAX_CLUSTERS > 1 ? $clog2(MAX_CLUSTERS) : 1;
  localparam int KW    = $clog2(MAX_CLUSTERS + 1);
  localparam int LBL_W = KW;
  localparam int SUM_W = COORD_W + CNTW;
  localparam int SQ_W  = 2 * COORD_W;
  localparam int D_W   = SQ_W + 1;
  localparam int NW    = ID_W + 2 * COORD_W;
  localparam logic [LBL_W-1:0] NO_LABEL = LBL_W'(MAX_CLUSTERS);

  logic [NC_W-1:0]  num_clusters;
  logic [MI_W-1:0]  max_iter;
  logic [CNTW-1:0]  loaded;
  logic [KW-1:0]    seeded;
  logic [CNTW-1:0]  i;
  logic [CW-1:0]    c;
  logic [MI_W-1:0]  it;
  logic             changed;
  logic [KW-1:0]    k;
  logic [PICK_W-1:0] pick_idx;

  logic signed [COORD_W-1:0] cen_x [MAX_CLUSTERS];
  logic signed [COORD_W-1:0] cen_y [MAX_CLUSTERS];
  logic signed [SUM_W-1:0]   sum_x [MAX_CLUSTERS];
  logic signed [SUM_W-1:0]   sum_y [MAX_CLUSTERS];
  logic [CNTW-1:0]           mcnt  [MAX_CLUSTERS];

  logic [NW-1:0]      node_rd;
  logic [ID_W-1:0]    rd_id;
  logic [COORD_W-1:0] rd_x;
  logic [COORD_W-1:0] rd_y;
  logic [LBL_W-1:0]   l_rd;
  logic [AW-1:0]      node_raddr;

  logic signed [COORD_W:0]     dx, dy;
  logic signed [2*COORD_W+1:0] px, py;
  logic [SQ_W-1:0]  sq_x, sq_y;
  logic [D_W-1:0]   dsum;
  logic [CW-1:0]    best;
  logic [D_W-1:0]   best_d;
  logic             hb_found;
  logic [D_W-1:0]   hb_d;
  logic [ID_W-1:0]  hb_id;
  logic [CW-1:0]    acc_idx;

  logic                       div_done;
  logic signed [COORD_W-1:0]  quot;

  assign rd_id = node_rd[NW-1 -: ID_W];
  assign rd_x  = node_rd[2*COORD_W-1 -: COORD_W];
  assign rd_y  = node_rd[COORD_W-1:0];
  assign node_raddr = ctl.sel_pick ? AW'(pick_index) : i[AW-1:0];

  kmh_ram #(.WIDTH(NW), .DEPTH(MAX_NODES)) u_node_ram (
    .clk   (clk),
    .we    (ctl.ld_wr && (loaded < CNTW'(MAX_NODES))),
    .waddr (loaded[AW-1:0]),
    .wdata ({node_id, x_coord, y_coord}),
    .raddr (node_raddr),
    .rdata (node_rd)
  );

  kmh_ram #(.WIDTH(LBL_W), .DEPTH(MAX_NODES)) u_label_ram (
    .clk   (clk),
    .we    (ctl.lbl_init || ctl.lbl_wr),
    .waddr (i[AW-1:0]),
    .wdata (ctl.lbl_init ? NO_LABEL : LBL_W'(best)),
    .raddr (i[AW-1:0]),
    .rdata (l_rd)
  );

  kmh_div #(.SUM_W(SUM_W), .CNT_W(CNTW)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (ctl.div_x_start || ctl.div_y_start),
    .dividend (ctl.div_y_start ? sum_y[c] : sum_x[c]),
    .divisor  (mcnt[c]),
    .done     (div_done),
    .quotient (quot)
  );

  always_comb begin
    if (num_clusters == '0) begin
      k = KW'(1);
    end else if (num_clusters > MAX_CLUSTERS) begin
      k = KW'(MAX_CLUSTERS);
    end else begin
      k = KW'(num_clusters);
    end
  end

  assign dx = $signed({rd_x[COORD_W-1], rd_x}) - $signed({cen_x[c][COORD_W-1], cen_x[c]});
  assign dy = $signed({rd_y[COORD_W-1], rd_y}) - $signed({cen_y[c][COORD_W-1], cen_y[c]});
  assign px = dx * dx;
  assign py = dy * dy;
  assign dsum = {1'b0, sq_x} + {1'b0, sq_y};
  assign acc_idx = l_rd[CW-1:0];

  assign sts.i_end    = (i == loaded);
  assign sts.c_last   = ((KW+1)'(c) + (KW+1)'(1)) == (KW+1)'(k);
  assign sts.it_end   = (it == max_iter);
  assign sts.changed  = changed;
  assign sts.cnt_zero = (mcnt[c] == '0);
  assign sts.div_done = div_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_clusters <= NC_RESET;
      max_iter     <= MI_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_NUM_CLUSTERS: num_clusters <= cfg_data[NC_W-1:0];
        REG_MAX_ITER:     max_iter <= cfg_data[MI_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      loaded <= '0;
      seeded <= '0;
      i      <= '0;
      c      <= '0;
      it     <= '0;
      changed <= 1'b0;
      done   <= 1'b0;
      for (int n = 0; n < MAX_CLUSTERS; n++) begin
        cen_x[n] <= '0;
        cen_y[n] <= '0;
      end
    end else begin
      done <= ctl.emit;
      if (ctl.clr) begin
        loaded <= '0;
        seeded <= '0;
        for (int n = 0; n < MAX_CLUSTERS; n++) begin
          cen_x[n] <= '0;
          cen_y[n] <= '0;
        end
      end
      if (ctl.ld_wr && (loaded < CNTW'(MAX_NODES))) begin
        loaded <= loaded + 1'b1;
      end
      if (ctl.pick_wr && (CNTW'(pick_idx) < loaded) && (seeded < KW'(MAX_CLUSTERS))) begin
        cen_x[seeded[CW-1:0]] <= $signed(rd_x);
        cen_y[seeded[CW-1:0]] <= $signed(rd_y);
        seeded <= seeded + 1'b1;
      end
      if (ctl.run_start) begin
        it <= '0;
      end
      if (ctl.it_inc) begin
        it <= it + 1'b1;
      end
      if (ctl.i_clr) begin
        i <= '0;
      end else if (ctl.i_inc) begin
        i <= i + 1'b1;
      end
      if (ctl.c_clr) begin
        c <= '0;
      end else if (ctl.c_inc) begin
        c <= c + 1'b1;
      end
      if (ctl.chg_clr) begin
        changed <= 1'b0;
      end else if (ctl.lbl_wr && (LBL_W'(best) != l_rd)) begin
        changed <= 1'b1;
      end
      if (ctl.cen_x_wr) begin
        cen_x[c] <= quot;
      end
      if (ctl.cen_y_wr) begin
        cen_y[c] <= quot;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.pick_lat) begin
      pick_idx <= pick_index;
    end
    if (ctl.mul) begin
      sq_x <= px[SQ_W-1:0];
      sq_y <= py[SQ_W-1:0];
    end
    if (ctl.cmp_as && ((c == '0) || (dsum < best_d))) begin
      best   <= c;
      best_d <= dsum;
    end
    if (ctl.sum_clr) begin
      for (int n = 0; n < MAX_CLUSTERS; n++) begin
        sum_x[n] <= '0;
        sum_y[n] <= '0;
        mcnt[n]  <= '0;
      end
    end else if (ctl.sum_acc) begin
      sum_x[acc_idx] <= sum_x[acc_idx] + $signed({{(SUM_W-COORD_W){rd_x[COORD_W-1]}}, rd_x});
      sum_y[acc_idx] <= sum_y[acc_idx] + $signed({{(SUM_W-COORD_W){rd_y[COORD_W-1]}}, rd_y});
      mcnt[acc_idx]  <= mcnt[acc_idx] + 1'b1;
    end
    if (ctl.hub_clr) begin
      hb_found <= 1'b0;
      hb_id    <= '0;
    end else if (ctl.hub_cmp && (l_rd == LBL_W'(c)) && (!hb_found || (dsum < hb_d))) begin
      hb_found <= 1'b1;
      hb_d     <= dsum;
      hb_id    <= rd_id;
    end
    if (ctl.emit) begin
      cluster   <= OUT_CL_W'(c);
      hub_id    <= hb_id;
      hub_found <= hb_found;
      last      <= sts.c_last;
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/kmeans_hub_selection.sv @@
// Top level of the k-means hub selection block.
//
// channel  direction  handshake             payload
// command  in         start & !busy         cmd, node_id, x_coord, y_coord, pick_index
// result   out        done (one cycle)      cluster, hub_id, hub_found, last
// config   in         cfg_we                cfg_index, cfg_data
//
// Clear and load complete in the idle state; pick also passes through S_PICK,
// since the node store read data is registered. Run: label init, then per
// round assignment, then summing and division while labels still change, and
// finally hub search; the shared distance unit and the single read port of
// the node store make these steps run one after another.
// Reset is synchronous; the result strobe cannot be stalled.
`timescale 1ns / 1ps
`default_nettype none
module kmeans_hub_selection
  import kmh_pkg::*;
#(
  parameter int MAX_NODES    = 64,
  parameter int MAX_CLUSTERS = 16
) (
  input  wire                       clk,
  input  wire                       rst,
  input  wire                       start,
  output logic                      busy,
  input  wire [1:0]                 cmd,
  input  wire [ID_W-1:0]            node_id,
  input  wire signed [COORD_W-1:0]  x_coord,
  input  wire signed [COORD_W-1:0]  y_coord,
  input  wire [PICK_W-1:0]          pick_index,
  output logic                      done,
  output logic [OUT_CL_W-1:0]       cluster,
  output logic [ID_W-1:0]           hub_id,
  output logic                      hub_found,
  output logic                      last,
  input  wire                       cfg_we,
  input  wire                       cfg_index,
  input  wire [CFG_W-1:0]           cfg_data
);

  ctl_t ctl;
  sts_t sts;

  kmh_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .cmd   (cmd),
    .sts   (sts),
    .busy  (busy),
    .ctl   (ctl)
  );

  kmh_dp #(.MAX_NODES(MAX_NODES), .MAX_CLUSTERS(MAX_CLUSTERS)) u_dp (
    .clk        (clk),
    .rst        (rst),
    .ctl        (ctl),
    .sts        (sts),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .node_id    (node_id),
    .x_coord    (x_coord),
    .y_coord    (y_coord),
    .pick_index (pick_index),
    .done       (done),
    .cluster    (cluster),
    .hub_id     (hub_id),
    .hub_found  (hub_found),
    .last       (last)
  );

  a_last_strobe: assert property (@(posedge clk) disable iff (rst)
    last && !done |-> !$past(ctl.emit))
    else $error("last flag raised without a result beat");

  a_run_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy && (cmd == CMD_RUN) |=> busy)
    else $error("run command did not start the sequencer");

  a_result_gap: assert property (@(posedge clk) disable iff (rst)
    done && !last |=> !done && busy)
    else $error("result beats not separated or run ended early");

  a_emit_busy: assert property (@(posedge clk) disable iff (rst)
    ctl.emit |-> busy)
    else $error("result issued while idle");

endmodule
`default_nettype wire

@@ tb/tb_kmeans_hub_selection.sv @@
// Self-checking testbench for kmeans_hub_selection: directed table plus random phases.
`timescale 1ns / 1ps
`default_nettype none
module tb_kmeans_hub_selection;
  import kmh_pkg::*;

  localparam int NODE_CAP  = 64;
  localparam int CLUS_CAP  = 16;
  localparam int WDOG_MAX  = 20000000;
  localparam int RAND_BEATS = 250;

  typedef struct {
    logic [OUT_CL_W-1:0] cluster;
    logic [ID_W-1:0]     hub_id;
    logic                hub_found;
    logic                last;
  } hub_res_t;

  typedef struct {
    cmd_t                op;
    logic [ID_W-1:0]     id;
    logic [COORD_W-1:0]  x;
    logic [COORD_W-1:0]  y;
    logic [PICK_W-1:0]   pick;
    bit                  no_hubs;
  } cmd_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic [1:0] cmd = CMD_CLEAR;
  logic [ID_W-1:0] node_id = '0;
  logic [COORD_W-1:0] x_coord = '0;
  logic [COORD_W-1:0] y_coord = '0;
  logic [PICK_W-1:0] pick_index = '0;
  logic cfg_we = 1'b0;
  logic cfg_index = REG_NUM_CLUSTERS;
  logic [CFG_W-1:0] cfg_data = '0;
  logic busy, done, hub_found, last;
  logic [OUT_CL_W-1:0] cluster;
  logic [ID_W-1:0] hub_id;

  kmeans_hub_selection dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .cmd(cmd), .node_id(node_id),
    .x_coord(x_coord), .y_coord(y_coord), .pick_index(pick_index), .done(done),
    .cluster(cluster), .hub_id(hub_id), .hub_found(hub_found), .last(last),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // shadow state of the block
  logic [ID_W-1:0] node_ids [NODE_CAP];
  int node_xs [NODE_CAP];
  int node_ys [NODE_CAP];
  int labels [NODE_CAP];
  int cen_x [CLUS_CAP];
  int cen_y [CLUS_CAP];
  int n_nodes = 0;
  int n_seeds = 0;
  int k_reg = 10;
  int iter_reg = 100;

  hub_res_t hub_q [$];
  cmd_row_t dir_rows [$];
  int fails = 0;
  int beats_sent = 0;
  bit calm = 1'b0;
  int wdog = 0;

  function automatic longint sq_dist(int i, int c);
    longint dx, dy;
    dx = longint'(node_xs[i]) - longint'(cen_x[c]);
    dy = longint'(node_ys[i]) - longint'(cen_y[c]);
    return dx * dx + dy * dy;
  endfunction

  function automatic void run_hubs();
    int k, best;
    bit moved, found;
    longint bd, d;
    longint sx [CLUS_CAP];
    longint sy [CLUS_CAP];
    int cnt [CLUS_CAP];
    logic [ID_W-1:0] hub;
    hub_res_t r;
    k = (k_reg < 1) ? 1 : (k_reg > CLUS_CAP) ? CLUS_CAP : k_reg;
    for (int i = 0; i < n_nodes; i++) labels[i] = CLUS_CAP;
    for (int it = 0; it < iter_reg; it++) begin
      moved = 1'b0;
      for (int i = 0; i < n_nodes; i++) begin
        best = 0;
        bd = sq_dist(i, 0);
        for (int c = 1; c < k; c++) begin
          d = sq_dist(i, c);
          if (d < bd) begin
            bd = d;
            best = c;
          end
        end
        if (labels[i] != best) begin
          moved = 1'b1;
          labels[i] = best;
        end
      end
      if (!moved) break;
      for (int c = 0; c < k; c++) begin
        sx[c] = 0;
        sy[c] = 0;
        cnt[c] = 0;
      end
      for (int i = 0; i < n_nodes; i++) begin
        sx[labels[i]] += node_xs[i];
        sy[labels[i]] += node_ys[i];
        cnt[labels[i]]++;
      end
      for (int c = 0; c < k; c++) begin
        if (cnt[c] != 0) begin
          cen_x[c] = int'(sx[c] / longint'(cnt[c]));
          cen_y[c] = int'(sy[c] / longint'(cnt[c]));
        end
      end
    end
    for (int c = 0; c < k; c++) begin
      found = 1'b0;
      bd = 0;
      hub = '0;
      for (int i = 0; i < n_nodes; i++) begin
        if (labels[i] == c) begin
          d = sq_dist(i, c);
          if (!found || d < bd) begin
            found = 1'b1;
            bd = d;
            hub = node_ids[i];
          end
        end
      end
      r.cluster = c[OUT_CL_W-1:0];
      r.hub_id = hub;
      r.hub_found = found;
      r.last = (c + 1 == k);
      hub_q.insert(hub_q.size(), r);
    end
  endfunction

  function automatic void apply_beat(cmd_row_t b);
    case (b.op)
      CMD_CLEAR: begin
        n_nodes = 0;
        n_seeds = 0;
        for (int c = 0; c < CLUS_CAP; c++) begin
          cen_x[c] = 0;
          cen_y[c] = 0;
        end
      end
      CMD_LOAD: begin
        if (n_nodes < NODE_CAP) begin
          node_ids[n_nodes] = b.id;
          node_xs[n_nodes] = int'($signed(b.x));
          node_ys[n_nodes] = int'($signed(b.y));
          n_nodes++;
        end
      end
      CMD_PICK: begin
        if (int'(b.pick) < n_nodes && n_seeds < CLUS_CAP) begin
          cen_x[n_seeds] = node_xs[b.pick];
          cen_y[n_seeds] = node_ys[b.pick];
          n_seeds++;
        end
      end
      default: run_hubs();
    endcase
  endfunction

  task automatic send(cmd_row_t b);
    int q0;
    hub_res_t r;
    if (!calm && $urandom_range(0, 99) < 16) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    start <= 1'b1;
    cmd <= b.op;
    node_id <= b.id;
    x_coord <= b.x;
    y_coord <= b.y;
    pick_index <= b.pick;
    @(posedge clk);
    while (busy) @(posedge clk);
    q0 = hub_q.size();
    apply_beat(b);
    if (b.no_hubs) begin
      for (int i = q0; i < hub_q.size(); i++) begin
        r = hub_q[i];
        r.hub_id = '0;
        r.hub_found = 1'b0;
        hub_q[i] = r;
      end
    end
    beats_sent++;
  endtask

  task automatic send_op(cmd_t op, logic [ID_W-1:0] id, logic [COORD_W-1:0] x,
                         logic [COORD_W-1:0] y, logic [PICK_W-1:0] pk);
    cmd_row_t b;
    b = '{op, id, x, y, pk, 1'b0};
    send(b);
  endtask

  task automatic settle();
    start <= 1'b0;
    @(posedge clk);
    while (hub_q.size() != 0 || busy) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, int val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[CFG_W-1:0];
    @(posedge clk);
    if (idx == REG_NUM_CLUSTERS) k_reg = val & 31;
    else iter_reg = val & 1023;
  endtask

  function automatic void add_row(cmd_t op, int id, int x, int y, int pk, bit nh);
    cmd_row_t b;
    b.op = op;
    b.id = id[ID_W-1:0];
    b.x = x[COORD_W-1:0];
    b.y = y[COORD_W-1:0];
    b.pick = pk[PICK_W-1:0];
    b.no_hubs = nh;
    dir_rows.insert(dir_rows.size(), b);
  endfunction

  always @(posedge clk) begin
    hub_res_t e;
    if (!rst && done) begin
      if (hub_q.size() == 0) begin
        $error("unexpected result: cluster %0d hub_id %0d", cluster, hub_id);
        fails++;
      end else begin
        e = hub_q.pop_front();
        if (cluster !== e.cluster) begin
          $error("cluster: expected %0d, got %0d", e.cluster, cluster);
          fails++;
        end
        if (hub_id !== e.hub_id) begin
          $error("hub_id: expected %0d, got %0d", e.hub_id, hub_id);
          fails++;
        end
        if (hub_found !== e.hub_found) begin
          $error("hub_found: expected %0d, got %0d", e.hub_found, hub_found);
          fails++;
        end
        if (last !== e.last) begin
          $error("last: expected %0d, got %0d", e.last, last);
          fails++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done || cfg_we) begin
      wdog <= 0;
    end else begin
      wdog <= wdog + 1;
      if (wdog >= WDOG_MAX) begin
        $display("tb_kmeans_hub_selection: done, errors");
        $finish;
      end
    end
  end

  initial begin
    int n, p, cx0, cy0, sel, kv, mv;
    int ctr_x [4];
    int ctr_y [4];
    bit wide;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    add_row(CMD_RUN, 0, 0, 0, 0, 1'b1);
    add_row(CMD_CLEAR, 0, 0, 0, 0, 1'b0);
    add_row(CMD_LOAD, 0, -32768, -32768, 0, 1'b0);
    add_row(CMD_LOAD, 65535, 32767, 32767, 63, 1'b0);
    add_row(CMD_LOAD, 16'h1234, 0, 0, 0, 1'b0);
    add_row(CMD_LOAD, 16'h5555, -1, 1, 0, 1'b0);
    add_row(CMD_LOAD, 16'haaaa, 32767, -32768, 0, 1'b0);
    add_row(CMD_PICK, 0, 0, 0, 0, 1'b0);
    add_row(CMD_PICK, 0, 0, 0, 63, 1'b0);
    add_row(CMD_PICK, 0, 0, 0, 1, 1'b0);
    add_row(CMD_PICK, 0, 0, 0, 4, 1'b0);
    add_row(CMD_RUN, 0, 0, 0, 0, 1'b0);
    add_row(CMD_RUN, 0, 0, 0, 0, 1'b0);
    add_row(CMD_LOAD, 7, 100, 100, 0, 1'b0);
    add_row(CMD_LOAD, 8, 100, 100, 0, 1'b0);
    add_row(CMD_RUN, 0, 0, 0, 0, 1'b0);
    add_row(CMD_CLEAR, 0, 0, 0, 0, 1'b0);
    add_row(CMD_RUN, 0, 0, 0, 0, 1'b1);
    foreach (dir_rows[i]) send(dir_rows[i]);

    beats_sent = 0;
    for (int ph = 0; beats_sent < RAND_BEATS; ph++) begin
      settle();
      case (ph)
        0: begin kv = 1;  mv = 1023; end
        1: begin kv = 16; mv = 1;    end
        2: begin kv = 0;  mv = 0;    end
        3: begin kv = 31; mv = 5;    end
        4: begin kv = 16; mv = 1023; end
        default: begin
          kv = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 31) : $urandom_range(1, 16);
          mv = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 1023) : $urandom_range(1, 20);
        end
      endcase
      write_reg(REG_NUM_CLUSTERS, kv | ($urandom_range(0, 31) << 5));
      write_reg(REG_MAX_ITER, mv);
      cfg_we <= 1'b0;
      calm = (beats_sent >= 100 && beats_sent < 160);
      if ($urandom_range(0, 3) != 0) send_op(CMD_CLEAR, $urandom, $urandom, $urandom, $urandom);
      n = ($urandom_range(0, 9) == 0 || ph == 4) ? $urandom_range(60, 70) : $urandom_range(0, 12);
      wide = ($urandom_range(0, 2) == 0);
      for (int c = 0; c < 4; c++) begin
        ctr_x[c] = $urandom_range(0, 60000) - 30000;
        ctr_y[c] = $urandom_range(0, 60000) - 30000;
      end
      for (int i = 0; i < n; i++) begin
        sel = $urandom_range(0, 3);
        cx0 = wide ? $urandom : ctr_x[sel] + $urandom_range(0, 400) - 200;
        cy0 = wide ? $urandom : ctr_y[sel] + $urandom_range(0, 400) - 200;
        send_op(CMD_LOAD, $urandom, cx0, cy0, $urandom);
        if ($urandom_range(0, 19) == 0)
          send_op(cmd_t'($urandom_range(1, 2)), $urandom, $urandom, $urandom, $urandom);
      end
      p = ($urandom_range(0, 7) == 0) ? 18 : $urandom_range(0, 6);
      for (int i = 0; i < p; i++) begin
        if (n_nodes > 0 && $urandom_range(0, 5) != 0)
          send_op(CMD_PICK, $urandom, $urandom, $urandom, $urandom_range(0, n_nodes - 1));
        else
          send_op(CMD_PICK, $urandom, $urandom, $urandom, $urandom);
      end
      send_op(CMD_RUN, $urandom, $urandom, $urandom, $urandom);
      if ($urandom_range(0, 2) == 0) send_op(CMD_RUN, $urandom, $urandom, $urandom, $urandom);
    end

    start <= 1'b0;
    @(posedge clk);
    while (hub_q.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (fails == 0) begin
      $display("tb_kmeans_hub_selection: done, clean");
    end else begin
      $display("tb_kmeans_hub_selection: done, errors");
    end
    $finish;
  end

endmodule
`default_nettype wire

@@ kmeans_hub_selection.f @@
rtl/core/kmh_pkg.sv
rtl/core/kmh_ram.sv
rtl/core/kmh_div.sv
rtl/core/kmh_ctrl.sv
rtl/core/kmh_dp.sv
rtl/core/kmeans_hub_selection.sv
tb/tb_kmeans_hub_selection.sv
